@@ src/fas_pkg.sv @@
// ----------------------------------------------------------------------------
// fas_pkg
// shared types, codes and defaults for the frame animation sequencer
// ----------------------------------------------------------------------------
package fas_pkg;

    // default parameter values
    localparam int MAX_FRAMES_DEF = 256;
    localparam int TIMER_BITS_DEF = 16;

    // field widths
    localparam int FRAME_COUNT_W = 9;
    localparam int FRAME_W       = 8;
    localparam int MS_W          = 16;
    localparam int CFG_INDEX_W   = 2;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_INTERVAL_MS = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_COOLDOWN_MS = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_LOOP_ENABLE = 2'd3;

    // configuration reset values
    localparam logic [MS_W-1:0] INTERVAL_RESET = 16'd100;

    // event kinds
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_PLAY  = 2'd1;
    localparam logic [1:0] KIND_PAUSE = 2'd2;
    localparam logic [1:0] KIND_SET   = 2'd3;

    // run mode codes as seen on the result
    localparam logic [1:0] MODE_PLAY     = 2'd0;
    localparam logic [1:0] MODE_PAUSE    = 2'd1;
    localparam logic [1:0] MODE_ENDED    = 2'd2;
    localparam logic [1:0] MODE_COOLDOWN = 2'd3;

    // internal run state, one-hot
    typedef enum logic [3:0] {
        ST_PLAY     = 4'b0001,
        ST_PAUSE    = 4'b0010,
        ST_ENDED    = 4'b0100,
        ST_COOLDOWN = 4'b1000
    } t_run_state;

    // input item
    typedef struct packed {
        logic [1:0]         kind;
        logic [FRAME_W-1:0] frame_select;
    } t_in_item;

    // result item
    typedef struct packed {
        logic [FRAME_W-1:0] current_frame;
        logic [1:0]         run_mode;
        logic               rejected;
    } t_out_item;

    // configuration seen by the core, frame count already clamped
    typedef struct packed {
        logic [FRAME_COUNT_W-1:0] usable_frames;
        logic [MS_W-1:0]          interval_ms;
        logic [MS_W-1:0]          cooldown_ms;
        logic                     loop_enable;
    } t_cfg;

endpackage

@@ src/frame_animation_sequencer.sv @@
// ----------------------------------------------------------------------------
// frame_animation_sequencer
// steps an animation frame index under tick, play, pause and set-frame events
// ----------------------------------------------------------------------------
// Events arrive on the input channel (valid/ready); each event yields exactly
// one result transaction on the output channel carrying the frame index, the
// run mode after the event and a reject flag for refused play or set-frame.
// An accepted event is held in the input register, then the state update
// and result are computed and captured in the output register, from which
// the result is offered. One event per cycle is sustained while the receiver
// does not stall; the limit is the single state update per clock in the core.
// When the receiver stalls, the output register holds its result and the
// input register takes one more event, after which input ready drops until
// the output drains. Configuration registers are written through a plain
// write port (enable, index, data); the user must write them only while the
// block is idle, which the block itself does not enforce.
// After reset the run mode is pause at frame 0, the frame count is 0, the
// interval is 100 ticks, cooldown is 0 and looping is off; playback starts
// only on an explicit play event.
// ----------------------------------------------------------------------------
module frame_animation_sequencer #(
    parameter int MAX_FRAMES = fas_pkg::MAX_FRAMES_DEF,
    parameter int TIMER_BITS = fas_pkg::TIMER_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  fas_pkg::t_in_item               i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output fas_pkg::t_out_item              o_out_data,
    input  logic                            i_cfg_we,
    input  logic [fas_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [fas_pkg::MS_W-1:0]        i_cfg_data
);

    fas_pkg::t_cfg      w_cfg;
    fas_pkg::t_in_item  r_in;
    fas_pkg::t_out_item r_out;
    fas_pkg::t_out_item w_result;
    logic               r_in_valid;
    logic               r_out_valid;
    logic               w_out_free;
    logic               w_go;
    logic               w_accept;

    // configuration registers
    fas_cfg #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // handshake control
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_go       = r_in_valid && w_out_free;
    assign o_in_ready = !r_in_valid || w_go;
    assign w_accept   = i_in_valid && o_in_ready;

    // sequencer state and event logic
    fas_core #(
        .TIMER_BITS (TIMER_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_go),
        .i_item   (r_in),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= i_in_data;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_go) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ src/fas_cfg.sv @@
// ----------------------------------------------------------------------------
// fas_cfg
// configuration registers with frame count clamping
// ----------------------------------------------------------------------------
module fas_cfg #(
    parameter int MAX_FRAMES = fas_pkg::MAX_FRAMES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [fas_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [fas_pkg::MS_W-1:0]            i_cfg_data,
    output fas_pkg::t_cfg                       o_cfg
);

    localparam int FRAME_LIMIT = (MAX_FRAMES < 256) ? MAX_FRAMES : 256;

    logic [fas_pkg::FRAME_COUNT_W-1:0] r_frame_count;
    logic [fas_pkg::MS_W-1:0]          r_interval_ms;
    logic [fas_pkg::MS_W-1:0]          r_cooldown_ms;
    logic                              r_loop_enable;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count <= '0;
            r_interval_ms <= fas_pkg::INTERVAL_RESET;
            r_cooldown_ms <= '0;
            r_loop_enable <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                fas_pkg::REG_FRAME_COUNT: begin
                    r_frame_count <= i_cfg_data[fas_pkg::FRAME_COUNT_W-1:0];
                end
                fas_pkg::REG_INTERVAL_MS: begin
                    r_interval_ms <= i_cfg_data;
                end
                fas_pkg::REG_COOLDOWN_MS: begin
                    r_cooldown_ms <= i_cfg_data;
                end
                fas_pkg::REG_LOOP_ENABLE: begin
                    r_loop_enable <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    // clamp frame count to the usable range
    always_comb begin
        if (r_frame_count > fas_pkg::FRAME_COUNT_W'(FRAME_LIMIT)) begin
            o_cfg.usable_frames = fas_pkg::FRAME_COUNT_W'(FRAME_LIMIT);
        end else begin
            o_cfg.usable_frames = r_frame_count;
        end
        o_cfg.interval_ms = r_interval_ms;
        o_cfg.cooldown_ms = r_cooldown_ms;
        o_cfg.loop_enable = r_loop_enable;
    end

endmodule

@@ src/fas_core.sv @@
// ----------------------------------------------------------------------------
// fas_core
// run state, frame position and timers, updated once per event
// ----------------------------------------------------------------------------
module fas_core #(
    parameter int TIMER_BITS = fas_pkg::TIMER_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  fas_pkg::t_in_item   i_item,
    input  fas_pkg::t_cfg       i_cfg,
    output fas_pkg::t_out_item  o_result
);

    localparam logic [32:0] TIMER_MAX = (33'd1 << TIMER_BITS) - 33'd1;

    // load a timer with a duration, saturated to the timer width
    function automatic logic [TIMER_BITS-1:0] timer_load(input logic [fas_pkg::MS_W-1:0] ms);
        logic [32:0] ext;
        begin
            ext = 33'(ms);
            if (ext > TIMER_MAX) begin
                return TIMER_BITS'(TIMER_MAX);
            end
            return TIMER_BITS'(ext);
        end
    endfunction

    // map one-hot state to the result code
    function automatic logic [1:0] mode_code(input fas_pkg::t_run_state st);
        logic [1:0] code;
        begin
            code = fas_pkg::MODE_PAUSE;
            unique case (st)
                fas_pkg::ST_PLAY:     code = fas_pkg::MODE_PLAY;
                fas_pkg::ST_PAUSE:    code = fas_pkg::MODE_PAUSE;
                fas_pkg::ST_ENDED:    code = fas_pkg::MODE_ENDED;
                fas_pkg::ST_COOLDOWN: code = fas_pkg::MODE_COOLDOWN;
                default:              code = fas_pkg::MODE_PAUSE;
            endcase
            return code;
        end
    endfunction

    fas_pkg::t_run_state               r_run, n_run;
    logic [fas_pkg::FRAME_W-1:0]       r_pos, n_pos;
    logic [TIMER_BITS-1:0]             r_fcnt, n_fcnt;
    logic [TIMER_BITS-1:0]             r_ccnt, n_ccnt;
    logic                              r_chosen, n_chosen;

    logic                              w_empty;
    logic                              w_rej;
    logic [TIMER_BITS-1:0]             w_fdec;
    logic [TIMER_BITS-1:0]             w_cdec;
    logic [fas_pkg::FRAME_COUNT_W-1:0] w_next_pos;
    logic [fas_pkg::FRAME_COUNT_W-1:0] w_last;

    // timer decrements that stop at zero
    assign w_fdec     = (r_fcnt != '0) ? (r_fcnt - TIMER_BITS'(1)) : '0;
    assign w_cdec     = (r_ccnt != '0) ? (r_ccnt - TIMER_BITS'(1)) : '0;
    assign w_empty    = (i_cfg.usable_frames == '0);
    assign w_next_pos = fas_pkg::FRAME_COUNT_W'(r_pos) + fas_pkg::FRAME_COUNT_W'(1);
    assign w_last     = i_cfg.usable_frames - fas_pkg::FRAME_COUNT_W'(1);

    // event decode and next state
    always_comb begin
        n_run    = r_run;
        n_pos    = r_pos;
        n_fcnt   = r_fcnt;
        n_ccnt   = r_ccnt;
        n_chosen = r_chosen;
        w_rej    = 1'b0;
        unique case (i_item.kind)
            fas_pkg::KIND_TICK: begin
                if (!w_empty) begin
                    unique case (r_run)
                        fas_pkg::ST_COOLDOWN: begin
                            n_ccnt = w_cdec;
                            // cooldown over: restart playback
                            if (w_cdec == '0) begin
                                if (!r_chosen) begin
                                    n_pos = '0;
                                end
                                n_chosen = 1'b0;
                                n_run    = fas_pkg::ST_PLAY;
                                n_fcnt   = timer_load(i_cfg.interval_ms);
                            end
                        end
                        fas_pkg::ST_PLAY: begin
                            n_fcnt = w_fdec;
                            if (w_fdec == '0) begin
                                if (w_next_pos < i_cfg.usable_frames) begin
                                    n_pos  = w_next_pos[fas_pkg::FRAME_W-1:0];
                                    n_fcnt = timer_load(i_cfg.interval_ms);
                                end else begin
                                    // last frame reached, or count lowered below the position
                                    n_pos = w_last[fas_pkg::FRAME_W-1:0];
                                    if (i_cfg.loop_enable) begin
                                        n_ccnt = timer_load(i_cfg.cooldown_ms);
                                        n_run  = fas_pkg::ST_COOLDOWN;
                                    end else begin
                                        n_run = fas_pkg::ST_ENDED;
                                    end
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            fas_pkg::KIND_PLAY: begin
                if (w_empty) begin
                    w_rej = 1'b1;
                end else if (r_run != fas_pkg::ST_PLAY) begin
                    if (r_run == fas_pkg::ST_ENDED || r_run == fas_pkg::ST_COOLDOWN) begin
                        if (!r_chosen) begin
                            n_pos = '0;
                        end
                        n_chosen = 1'b0;
                    end
                    n_run  = fas_pkg::ST_PLAY;
                    n_fcnt = timer_load(i_cfg.interval_ms);
                end
            end
            fas_pkg::KIND_PAUSE: begin
                if (r_run == fas_pkg::ST_PLAY || r_run == fas_pkg::ST_COOLDOWN) begin
                    n_run = fas_pkg::ST_PAUSE;
                end
            end
            fas_pkg::KIND_SET: begin
                if (fas_pkg::FRAME_COUNT_W'(i_item.frame_select) >= i_cfg.usable_frames) begin
                    w_rej = 1'b1;
                end else begin
                    n_pos    = i_item.frame_select;
                    n_chosen = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run    <= fas_pkg::ST_PAUSE;
            r_pos    <= '0;
            r_fcnt   <= '0;
            r_ccnt   <= '0;
            r_chosen <= 1'b0;
        end else if (i_fire) begin
            r_run    <= n_run;
            r_pos    <= n_pos;
            r_fcnt   <= n_fcnt;
            r_ccnt   <= n_ccnt;
            r_chosen <= n_chosen;
        end
    end

    // result reflects the state after the event
    assign o_result.current_frame = n_pos;
    assign o_result.run_mode      = mode_code(n_run);
    assign o_result.rejected      = w_rej;

endmodule

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// checks the frame animation sequencer against a cycle-free prediction of its
// frame index, run mode and reject flag, one result per event, under random
// sender bursts, receiver stalls and a series of register settings
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import fas_pkg::*;

    localparam int IDLE_LIMIT = 1000;

    // dut connections
    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_in_valid  = 1'b0;
    logic                   o_in_ready;
    t_in_item               i_in_data   = '0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b1;
    t_out_item              o_out_data;
    logic                   i_cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [MS_W-1:0]        i_cfg_data  = '0;

    // register shadow, reset values of the block
    logic [FRAME_COUNT_W-1:0] cfg_frame_count = '0;
    logic [MS_W-1:0]          cfg_interval    = INTERVAL_RESET;
    logic [MS_W-1:0]          cfg_cooldown    = '0;
    logic                     cfg_loop        = 1'b0;

    // predicted sequencer state
    logic [1:0]         play_mode      = MODE_PAUSE;
    logic [FRAME_W-1:0] frame_pos      = '0;
    logic [MS_W-1:0]    frame_timer    = '0;
    logic [MS_W-1:0]    cooldown_timer = '0;
    logic               frame_chosen   = 1'b0;

    // frames still to be shown by the dut, oldest first
    t_out_item frame_results_due[$];

    int error_count = 0;
    int burst_left  = 0;
    int idle_cycles = 0;
    int ready_left  = 0;
    int ready_mode  = 0;
    int stall_phase = 0;

    frame_animation_sequencer i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // start or resume playback, sequence known to be non-empty
    function automatic void resume_playback();
        if (play_mode == MODE_PLAY) return;
        if (play_mode == MODE_ENDED || play_mode == MODE_COOLDOWN) begin
            if (!frame_chosen) frame_pos = '0;
            frame_chosen = 1'b0;
        end
        play_mode   = MODE_PLAY;
        frame_timer = cfg_interval;
    endfunction

    // apply one event to the predicted state and return the frame it shows
    function automatic t_out_item advance_animation(input t_in_item ev);
        logic [8:0] frames;
        logic [8:0] next_pos;
        t_out_item  res;
        frames = (cfg_frame_count > 9'd256) ? 9'd256 : cfg_frame_count;
        res.rejected = 1'b0;
        case (ev.kind)
            KIND_TICK: begin
                if (frames != 0 && play_mode == MODE_COOLDOWN) begin
                    if (cooldown_timer != 0) cooldown_timer = cooldown_timer - 1'b1;
                    if (cooldown_timer == 0) resume_playback();
                end else if (frames != 0 && play_mode == MODE_PLAY) begin
                    if (frame_timer != 0) frame_timer = frame_timer - 1'b1;
                    if (frame_timer == 0) begin
                        next_pos = {1'b0, frame_pos} + 9'd1;
                        if (next_pos < frames) begin
                            frame_pos   = next_pos[7:0];
                            frame_timer = cfg_interval;
                        end else begin
                            // last frame, or count lowered below the position
                            next_pos  = frames - 9'd1;
                            frame_pos = next_pos[7:0];
                            if (cfg_loop) begin
                                cooldown_timer = cfg_cooldown;
                                play_mode      = MODE_COOLDOWN;
                            end else begin
                                play_mode = MODE_ENDED;
                            end
                        end
                    end
                end
            end
            KIND_PLAY: begin
                if (frames == 0) res.rejected = 1'b1;
                else resume_playback();
            end
            KIND_PAUSE: begin
                if (play_mode == MODE_PLAY || play_mode == MODE_COOLDOWN) play_mode = MODE_PAUSE;
            end
            default: begin
                if (frames == 0 || {1'b0, ev.frame_select} >= frames) begin
                    res.rejected = 1'b1;
                end else begin
                    frame_pos    = ev.frame_select;
                    frame_chosen = 1'b1;
                end
            end
        endcase
        res.current_frame = frame_pos;
        res.run_mode      = play_mode;
        return res;
    endfunction

    // one input transaction, with random gaps between bursts
    task automatic send_event(input logic [1:0] kind, input logic [FRAME_W-1:0] sel);
        t_in_item ev;
        ev.kind         = kind;
        ev.frame_select = sel;
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 30);
        end
        burst_left = burst_left - 1;
        i_in_valid <= 1'b1;
        i_in_data  <= ev;
        do @(posedge i_clk); while (!o_in_ready);
        frame_results_due.push_back(advance_animation(ev));
    endtask

    // stop sending and wait until every predicted frame has come back
    task automatic wait_drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (frame_results_due.size() != 0);
    endtask

    // register write, block idle
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [MS_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        case (idx)
            REG_FRAME_COUNT: cfg_frame_count = value[FRAME_COUNT_W-1:0];
            REG_INTERVAL_MS: cfg_interval    = value;
            REG_COOLDOWN_MS: cfg_cooldown    = value;
            default:         cfg_loop        = value[0];
        endcase
        i_cfg_we <= 1'b0;
    endtask

    task automatic configure(input logic [MS_W-1:0] frames, input logic [MS_W-1:0] interval,
                             input logic [MS_W-1:0] cooldown, input logic [MS_W-1:0] looping);
        write_reg(REG_FRAME_COUNT, frames);
        write_reg(REG_INTERVAL_MS, interval);
        write_reg(REG_COOLDOWN_MS, cooldown);
        write_reg(REG_LOOP_ENABLE, looping);
    endtask

    // out of reset the sequence is empty: play and set-frame are refused
    task automatic test_empty_sequence();
        send_event(KIND_PLAY, 8'd0);
        send_event(KIND_SET, 8'd0);
        send_event(KIND_SET, 8'd255);
        send_event(KIND_TICK, 8'd255);
        send_event(KIND_PAUSE, 8'd170);
        send_event(KIND_TICK, 8'd85);
        wait_drain();
    endtask

    // reset interval of 100 ticks and reset cooldown/looping off
    task automatic test_reset_timing();
        write_reg(REG_FRAME_COUNT, 16'd2);
        send_event(KIND_PLAY, 8'd0);
        repeat (201) send_event(KIND_TICK, 8'($urandom_range(0, 255)));
        send_event(KIND_PAUSE, 8'd0);
        wait_drain();
    endtask

    // end of sequence, replay, out-of-range select, pause/resume
    task automatic test_end_and_replay();
        configure(16'd2, 16'd1, 16'd0, 16'd0);
        send_event(KIND_PLAY, 8'd0);
        send_event(KIND_PLAY, 8'd0);
        send_event(KIND_TICK, 8'd0);
        send_event(KIND_TICK, 8'd0);
        send_event(KIND_TICK, 8'd0);
        send_event(KIND_PAUSE, 8'd0);
        send_event(KIND_PLAY, 8'd0);
        send_event(KIND_SET, 8'd1);
        send_event(KIND_SET, 8'd2);
        send_event(KIND_PAUSE, 8'd0);
        send_event(KIND_TICK, 8'd0);
        send_event(KIND_PLAY, 8'd0);
        wait_drain();
    endtask

    // looping through cooldown, chosen frame kept across restart, zero interval
    task automatic test_cooldown_loop();
        configure(16'd1, 16'd0, 16'd1, 16'd1);
        send_event(KIND_TICK, 8'd0);
        send_event(KIND_TICK, 8'd0);
        send_event(KIND_TICK, 8'd0);
        send_event(KIND_PAUSE, 8'd0);
        send_event(KIND_SET, 8'd0);
        send_event(KIND_PLAY, 8'd0);
        send_event(KIND_TICK, 8'd0);
        send_event(KIND_PLAY, 8'd0);
        wait_drain();
    endtask

    // oversized frame count clamps to 256, longest timers, then count lowered
    // below the position so the next advance clamps to the last frame
    task automatic test_count_limits();
        configure(16'hFF2C, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_event(KIND_SET, 8'd255);
        send_event(KIND_PLAY, 8'd0);
        send_event(KIND_TICK, 8'd255);
        send_event(KIND_PAUSE, 8'd0);
        wait_drain();
        configure(16'd4, 16'd1, 16'd0, 16'd0);
        send_event(KIND_PLAY, 8'd0);
        send_event(KIND_TICK, 8'd0);
        wait_drain();
    endtask

    // random sessions, each with its own register setting
    task automatic test_random_sessions();
        logic [MS_W-1:0]    frames;
        logic [MS_W-1:0]    interval;
        logic [MS_W-1:0]    cooldown;
        logic [MS_W-1:0]    looping;
        logic [1:0]         kind;
        logic [FRAME_W-1:0] sel;
        int                 usable;
        int                 pick;
        for (int s = 0; s < 12; s++) begin
            case ($urandom_range(0, 9))
                0:       frames = 16'd0;
                1:       frames = 16'd1;
                5:       frames = 16'd256;
                6:       frames = 16'($urandom_range(257, 511));
                7:       frames = 16'($urandom_range(9, 255));
                8, 9:    frames = 16'($urandom_range(2, 20));
                default: frames = 16'($urandom_range(2, 8));
            endcase
            // upper bits beyond the register are ignored
            if ($urandom_range(0, 3) == 0) frames[15:9] = 7'($urandom);
            case ($urandom_range(0, 9))
                0:       interval = 16'd0;
                1:       interval = 16'd1;
                7:       interval = 16'hFFFF;
                8:       interval = 16'($urandom_range(5, 30));
                9:       interval = 16'($urandom);
                default: interval = 16'($urandom_range(0, 4));
            endcase
            case ($urandom_range(0, 9))
                0:       cooldown = 16'd0;
                1:       cooldown = 16'd1;
                7:       cooldown = 16'hFFFF;
                8:       cooldown = 16'($urandom_range(5, 30));
                9:       cooldown = 16'($urandom);
                default: cooldown = 16'($urandom_range(0, 4));
            endcase
            looping = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 1)) : 16'($urandom);
            configure(frames, interval, cooldown, looping);
            usable = (cfg_frame_count > 9'd256) ? 256 : int'(cfg_frame_count);

            repeat ($urandom_range(90, 146)) begin
                pick = $urandom_range(0, 99);
                if (pick < 62)      kind = KIND_TICK;
                else if (pick < 74) kind = KIND_PLAY;
                else if (pick < 84) kind = KIND_PAUSE;
                else                kind = KIND_SET;
                // selects mostly in range, some on the boundary, some anywhere
                pick = $urandom_range(0, 19);
                if (usable == 0 || pick < 3) sel = 8'($urandom_range(0, 255));
                else if (pick < 5)           sel = (usable - 1 + pick - 3 > 255) ? 8'd255
                                                   : 8'(usable - 1 + pick - 3);
                else                         sel = 8'($urandom_range(0, usable - 1));
                send_event(kind, sel);
            end
            wait_drain();
        end
    endtask

    // receiver: stretches of full rate, random stalls and periodic stalls
    always @(posedge i_clk) begin
        if (ready_left == 0) begin
            ready_mode = $urandom_range(0, 2);
            ready_left = $urandom_range(20, 200);
        end
        ready_left = ready_left - 1;
        case (ready_mode)
            0:       i_out_ready <= 1'b1;
            1:       i_out_ready <= ($urandom_range(0, 3) != 0);
            default: begin
                i_out_ready <= (stall_phase % 11) > 6;
                stall_phase = stall_phase + 1;
            end
        endcase
    end

    // compare each result transaction with the oldest predicted frame
    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (frame_results_due.size() == 0) begin
                $display("%0t: result with none due, frame %0d mode %0d rejected %0d",
                         $time, o_out_data.current_frame, o_out_data.run_mode,
                         o_out_data.rejected);
                error_count = error_count + 1;
            end else begin
                want = frame_results_due.pop_front();
                if (o_out_data.current_frame !== want.current_frame) begin
                    $display("%0t: current_frame expected %0d, got %0d",
                             $time, want.current_frame, o_out_data.current_frame);
                    error_count = error_count + 1;
                end
                if (o_out_data.run_mode !== want.run_mode) begin
                    $display("%0t: run_mode expected %0d, got %0d",
                             $time, want.run_mode, o_out_data.run_mode);
                    error_count = error_count + 1;
                end
                if (o_out_data.rejected !== want.rejected) begin
                    $display("%0t: rejected expected %0d, got %0d",
                             $time, want.rejected, o_out_data.rejected);
                    error_count = error_count + 1;
                end
            end
        end
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    // test sequence
    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_sequence();
        test_reset_timing();
        test_end_and_replay();
        test_cooldown_loop();
        test_count_limits();
        test_random_sessions();
        wait_drain();
        repeat (10) @(posedge i_clk);
        if (error_count == 0 && frame_results_due.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
